// ----- rtl/midi_mono_note_event_handler_core_assert.svh -----
// Assertion macros shared by the note handler RTL.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef MIDI_MONO_NOTE_EVENT_HANDLER_CORE_ASSERT_SVH
`define MIDI_MONO_NOTE_EVENT_HANDLER_CORE_ASSERT_SVH

`ifndef SYNTH

`define MMNH_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define MMNH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define MMNH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MMNH_ASSERT(label, cond, msg)

`define MMNH_ASSERT_IMP(label, ante, cons, msg)

`define MMNH_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/mmnh_pkg.sv -----
`timescale 1ns / 1ps

package mmnh_pkg;

  // Upper nibble of the status byte.
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CONTROL  = 4'hB;
  localparam logic [3:0] KIND_BEND     = 4'hE;

  // Controller numbers.
  localparam logic [6:0] CTRL_FEEDBACK = 7'd1;
  localparam logic [6:0] CTRL_DECAY    = 7'd2;
  localparam logic [6:0] CTRL_SUSTAIN  = 7'd3;
  localparam logic [6:0] CTRL_RELTIME  = 7'd4;
  localparam logic [6:0] CTRL_CUTOFF   = 7'd7;

  // Event codes.
  localparam logic [2:0] ACT_START    = 3'd0;
  localparam logic [2:0] ACT_RELEASE  = 3'd1;
  localparam logic [2:0] ACT_CUTOFF   = 3'd2;
  localparam logic [2:0] ACT_FEEDBACK = 3'd3;
  localparam logic [2:0] ACT_DECAY    = 3'd4;
  localparam logic [2:0] ACT_SUSTAIN  = 3'd5;
  localparam logic [2:0] ACT_RELTIME  = 3'd6;
  localparam logic [2:0] ACT_MIX      = 3'd7;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } msg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [6:0]  note_number;
    logic [13:0] param_value;
  } event_t;

  typedef struct packed {
    logic   emit;
    event_t evt;
  } result_t;

endpackage

// ----- rtl/mmnh_in_stage.sv -----
`timescale 1ns / 1ps

`include "midi_mono_note_event_handler_core_assert.svh"

module mmnh_in_stage
  import mmnh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [7:0] status_byte,
  input  logic [6:0] data_one,
  input  logic [6:0] data_two,
  input  logic       advance,
  output logic       stage_valid,
  output msg_t       msg
);

  logic accept;

  // The held item may be replaced in the same cycle that it moves on.
  assign req_stall = stage_valid && !advance;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      msg <= '{status_byte: status_byte, data_one: data_one, data_two: data_two};
    end
  end

  `MMNH_ASSERT_IMP(a_advance_needs_item, advance, stage_valid,
                   "advance without a held item")
  `MMNH_ASSERT_NXT(a_accept_fills, accept, stage_valid,
                   "accepted item not held in the input stage")
  `MMNH_ASSERT_IMP(a_stall_when_full, req_stall, stage_valid,
                   "input stalled while the stage is empty")

endmodule

// ----- rtl/mmnh_voice.sv -----
`timescale 1ns / 1ps

`include "midi_mono_note_event_handler_core_assert.svh"

module mmnh_voice
  import mmnh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  msg_t    msg,
  output result_t result
);

  logic [6:0] sounding_note, sounding_note_next;
  logic       sounding_flag, sounding_flag_next;
  logic [6:0] waiting_note, waiting_note_next;
  logic       waiting_flag, waiting_flag_next;

  logic [3:0] kind;
  logic       ends_sounding;

  assign kind = msg.status_byte[7:4];

  always_comb begin
    sounding_note_next = sounding_note;
    sounding_flag_next = sounding_flag;
    waiting_note_next  = waiting_note;
    waiting_flag_next  = waiting_flag;
    ends_sounding      = 1'b0;
    result             = '0;

    unique case (kind)
      KIND_NOTE_ON: begin
        if (msg.data_two != 7'd0) begin
          if (sounding_flag) begin
            waiting_note_next  = msg.data_one;
            waiting_flag_next  = 1'b1;
            result.emit        = 1'b1;
            result.evt.action  = ACT_RELEASE;
          end else begin
            sounding_note_next    = msg.data_one;
            sounding_flag_next    = 1'b1;
            result.emit           = 1'b1;
            result.evt.action     = ACT_START;
            result.evt.note_number = msg.data_one;
          end
        end else if (sounding_note == msg.data_one) begin
          ends_sounding = 1'b1;
        end
      end
      KIND_NOTE_OFF: begin
        if (sounding_note == msg.data_one) begin
          ends_sounding = 1'b1;
        end else if (waiting_flag && waiting_note == msg.data_one) begin
          waiting_flag_next = 1'b0;
          waiting_note_next = 7'd0;
        end
      end
      KIND_CONTROL: begin
        result.evt.param_value = {7'd0, msg.data_two};
        unique case (msg.data_one)
          CTRL_CUTOFF: begin
            result.emit       = 1'b1;
            result.evt.action = ACT_CUTOFF;
          end
          CTRL_FEEDBACK: begin
            result.emit       = 1'b1;
            result.evt.action = ACT_FEEDBACK;
          end
          CTRL_DECAY: begin
            result.emit       = 1'b1;
            result.evt.action = ACT_DECAY;
          end
          CTRL_SUSTAIN: begin
            result.emit       = 1'b1;
            result.evt.action = ACT_SUSTAIN;
          end
          CTRL_RELTIME: begin
            result.emit       = 1'b1;
            result.evt.action = ACT_RELTIME;
          end
          default: begin
            result.evt.param_value = 14'd0;
          end
        endcase
      end
      KIND_BEND: begin
        result.emit            = 1'b1;
        result.evt.action      = ACT_MIX;
        result.evt.param_value = {msg.data_two, msg.data_one};
      end
      default: begin
        result = '0;
      end
    endcase

    // The sounding note went off: hand over to the waiting note if one is held.
    if (ends_sounding) begin
      result.emit = 1'b1;
      if (waiting_flag) begin
        sounding_note_next     = waiting_note;
        sounding_flag_next     = 1'b1;
        waiting_flag_next      = 1'b0;
        waiting_note_next      = 7'd0;
        result.evt.action      = ACT_START;
        result.evt.note_number = waiting_note;
      end else begin
        sounding_flag_next = 1'b0;
        result.evt.action  = ACT_RELEASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sounding_note <= 7'd0;
      sounding_flag <= 1'b0;
      waiting_note  <= 7'd0;
      waiting_flag  <= 1'b0;
    end else if (advance) begin
      sounding_note <= sounding_note_next;
      sounding_flag <= sounding_flag_next;
      waiting_note  <= waiting_note_next;
      waiting_flag  <= waiting_flag_next;
    end
  end

  `MMNH_ASSERT_IMP(a_wait_needs_sound, waiting_flag, sounding_flag,
                   "a note waits while none sounds")
  `MMNH_ASSERT_IMP(a_empty_slot_zero, !waiting_flag, waiting_note == 7'd0,
                   "empty waiting slot holds a note number")
  `MMNH_ASSERT_NXT(a_hold_without_item, !advance,
                   $stable(sounding_note) && $stable(waiting_note),
                   "note state changed without an item")

endmodule

// ----- rtl/mmnh_out_stage.sv -----
`timescale 1ns / 1ps

module mmnh_out_stage
  import mmnh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  result_t     result,
  output logic        evt_valid,
  input  logic        evt_stall,
  output logic [2:0]  action,
  output logic [6:0]  note_number,
  output logic [13:0] param_value
);

  event_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (advance) begin
      evt_valid <= result.emit;
    end else if (!evt_stall) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held <= result.evt;
    end
  end

  assign action      = held.action;
  assign note_number = held.note_number;
  assign param_value = held.param_value;

endmodule

// ----- rtl/midi_mono_note_event_handler_core.sv -----
`timescale 1ns / 1ps

// Monophonic MIDI note handler with one waiting note.
// Request channel (req_valid / req_stall): one MIDI channel message per item,
// given as status_byte, data_one and data_two; the channel nibble is ignored.
// Event channel (evt_valid / evt_stall): zero or one event per message, given as
// action, note_number and param_value.
// An item is taken at a clock edge with valid high and stall low.
// An event is shown once its message has gone through the input register and
// then the event register. Throughput: one message per cycle unless evt_stall
// holds a shown event, set by the note state update between the two registers.
// Messages that give no event still pass through both registers.
// Stall: while evt_stall holds a shown event, that event stays and the input
// register keeps one more message, after which req_stall rises.
// Reset (rst, synchronous): sounding and waiting notes and both flags are cleared
// and both registers are emptied; a message can be taken as soon as rst is low.

`include "midi_mono_note_event_handler_core_assert.svh"

module midi_mono_note_event_handler_core
  import mmnh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [7:0]  status_byte,
  input  logic [6:0]  data_one,
  input  logic [6:0]  data_two,
  output logic        evt_valid,
  input  logic        evt_stall,
  output logic [2:0]  action,
  output logic [6:0]  note_number,
  output logic [13:0] param_value
);

  logic    stage_valid;
  logic    advance;
  msg_t    msg;
  result_t result;

  // The held item moves on whenever the event register is free or being taken.
  assign advance = stage_valid && (!evt_valid || !evt_stall);

  mmnh_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .status_byte (status_byte),
    .data_one    (data_one),
    .data_two    (data_two),
    .advance     (advance),
    .stage_valid (stage_valid),
    .msg         (msg)
  );

  mmnh_voice u_voice (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .msg     (msg),
    .result  (result)
  );

  mmnh_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .result      (result),
    .evt_valid   (evt_valid),
    .evt_stall   (evt_stall),
    .action      (action),
    .note_number (note_number),
    .param_value (param_value)
  );

  `MMNH_ASSERT_IMP(a_note_only_on_start, evt_valid && action != ACT_START,
                   note_number == 7'd0, "note number set on a non-start event")
  `MMNH_ASSERT_IMP(a_no_value_on_note,
                   evt_valid && (action == ACT_START || action == ACT_RELEASE),
                   param_value == 14'd0, "parameter value set on a note event")
  `MMNH_ASSERT_NXT(a_stalled_event_kept, evt_valid && evt_stall, evt_valid,
                   "stalled event dropped")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import mmnh_pkg::*;

  localparam int MESSAGE_TARGET = 1450;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int DRAIN_CYCLES   = 16;

  // Tracks the note state and holds the events that the handler still owes.
  class note_tracker;
    logic [6:0] sounding_note;
    bit         sounding_on;
    logic [6:0] waiting_note;
    bit         waiting_on;
    event_t     owed_events[$];
    int         mismatches;

    function new();
      sounding_note = '0;
      sounding_on   = 1'b0;
      waiting_note  = '0;
      waiting_on    = 1'b0;
      mismatches    = 0;
    endfunction

    function void add_event(logic [2:0] act, logic [6:0] note, logic [13:0] value);
      event_t ev;
      ev.action      = act;
      ev.note_number = note;
      ev.param_value = value;
      owed_events.push_back(ev);
    endfunction

    // The sounding note goes off: the waiting note takes over, or the envelope ends.
    function void end_sounding();
      sounding_on = 1'b0;
      if (waiting_on) begin
        sounding_note = waiting_note;
        sounding_on   = 1'b1;
        waiting_on    = 1'b0;
        waiting_note  = '0;
        add_event(ACT_START, sounding_note, '0);
      end else begin
        add_event(ACT_RELEASE, '0, '0);
      end
    endfunction

    function void take_message(logic [7:0] status, logic [6:0] d1, logic [6:0] d2);
      logic [3:0] kind;
      kind = status[7:4];
      case (kind)
        KIND_NOTE_ON: begin
          if (d2 != 7'd0) begin
            if (sounding_on) begin
              waiting_note = d1;
              waiting_on   = 1'b1;
              add_event(ACT_RELEASE, '0, '0);
            end else begin
              sounding_note = d1;
              sounding_on   = 1'b1;
              add_event(ACT_START, d1, '0);
            end
          end else if (sounding_note == d1) begin
            end_sounding();
          end
        end
        KIND_NOTE_OFF: begin
          if (sounding_note == d1) begin
            end_sounding();
          end else if (waiting_on && waiting_note == d1) begin
            waiting_on   = 1'b0;
            waiting_note = '0;
          end
        end
        KIND_CONTROL: begin
          case (d1)
            CTRL_CUTOFF:   add_event(ACT_CUTOFF, '0, {7'd0, d2});
            CTRL_FEEDBACK: add_event(ACT_FEEDBACK, '0, {7'd0, d2});
            CTRL_DECAY:    add_event(ACT_DECAY, '0, {7'd0, d2});
            CTRL_SUSTAIN:  add_event(ACT_SUSTAIN, '0, {7'd0, d2});
            CTRL_RELTIME:  add_event(ACT_RELTIME, '0, {7'd0, d2});
            default: ;
          endcase
        end
        KIND_BEND: add_event(ACT_MIX, '0, {d2, d1});
        default: ;
      endcase
    endfunction

    function void match_event(logic [2:0] act, logic [6:0] note, logic [13:0] value);
      event_t want;
      if (owed_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: action %0d note %0d value %0d", act, note, value);
      end else begin
        want = owed_events.pop_front();
        if (act !== want.action || note !== want.note_number ||
            value !== want.param_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected action %0d note %0d value %0d, got %0d %0d %0d",
                     want.action, want.note_number, want.param_value, act, note, value);
        end
      end
    endfunction

    function int outstanding();
      return owed_events.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [7:0]  status_byte = '0;
  logic [6:0]  data_one = '0;
  logic [6:0]  data_two = '0;
  logic        evt_valid;
  logic        evt_stall = 1'b0;
  logic [2:0]  action;
  logic [6:0]  note_number;
  logic [13:0] param_value;

  note_tracker tracker = new();
  int          cycles = 0;
  logic [6:0]  note_pool [6];

  midi_mono_note_event_handler_core dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .status_byte (status_byte),
    .data_one    (data_one),
    .data_two    (data_two),
    .evt_valid   (evt_valid),
    .evt_stall   (evt_stall),
    .action      (action),
    .note_number (note_number),
    .param_value (param_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Handshakes are sampled with the values that stood before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall)
        tracker.take_message(status_byte, data_one, data_two);
      if (evt_valid && !evt_stall)
        tracker.match_event(action, note_number, param_value);
    end
  end

  // Receiver back-pressure: each stretch picks one of four stall modes at random.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      evt_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 120);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: evt_stall <= 1'b0;
        1: evt_stall <= ($urandom_range(0, 1) == 1);
        2: evt_stall <= ($urandom_range(0, 7) != 0);
        default: evt_stall <= (cycles % 5 < 2);
      endcase
    end
  end

  function automatic msg_t make_msg(logic [7:0] status, logic [6:0] d1, logic [6:0] d2);
    msg_t m;
    m.status_byte = status;
    m.data_one    = d1;
    m.data_two    = d2;
    return m;
  endfunction

  // Mostly well-formed messages on a small set of notes, so that notes overlap.
  function automatic msg_t random_msg();
    int         pick;
    logic [3:0] chan;
    logic [6:0] note;
    logic [6:0] ctrl;
    pick = $urandom_range(0, 99);
    chan = 4'($urandom_range(0, 15));
    note = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                       : note_pool[$urandom_range(0, 5)];
    case ($urandom_range(0, 5))
      0: ctrl = CTRL_CUTOFF;
      1: ctrl = CTRL_FEEDBACK;
      2: ctrl = CTRL_DECAY;
      3: ctrl = CTRL_SUSTAIN;
      4: ctrl = CTRL_RELTIME;
      default: ctrl = 7'($urandom_range(0, 127));
    endcase
    if (pick < 35)
      return make_msg({KIND_NOTE_ON, chan}, note, 7'($urandom_range(1, 127)));
    if (pick < 60)
      return make_msg({KIND_NOTE_OFF, chan}, note, 7'($urandom_range(0, 127)));
    if (pick < 68)
      return make_msg({KIND_NOTE_ON, chan}, note, 7'd0);
    if (pick < 82)
      return make_msg({KIND_CONTROL, chan}, ctrl, 7'($urandom_range(0, 127)));
    if (pick < 90)
      return make_msg({KIND_BEND, chan}, 7'($urandom_range(0, 127)),
                      7'($urandom_range(0, 127)));
    return make_msg(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                    7'($urandom_range(0, 127)));
  endfunction

  task automatic send_msg(input msg_t m);
    req_valid   <= 1'b1;
    status_byte <= m.status_byte;
    data_one    <= m.data_one;
    data_two    <= m.data_two;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    msg_t       directed[$];
    msg_t       m;
    int         counted;
    int         burst;
    bit         drained_once;

    counted      = 0;
    drained_once = 1'b0;
    foreach (note_pool[i]) note_pool[i] = 7'($urandom_range(0, 127));

    // Remembered note off while nothing sounds, then the extreme notes.
    directed.push_back(make_msg({KIND_NOTE_OFF, 4'h0}, 7'd0, 7'd0));
    directed.push_back(make_msg({KIND_NOTE_ON, 4'h0}, 7'd0, 7'd127));
    directed.push_back(make_msg({KIND_NOTE_ON, 4'hF}, 7'd127, 7'd1));
    directed.push_back(make_msg({KIND_NOTE_ON, 4'h5}, 7'd64, 7'd0));
    // A zero-velocity note-on does not cancel the waiting note.
    directed.push_back(make_msg({KIND_NOTE_ON, 4'h0}, 7'd127, 7'd0));
    directed.push_back(make_msg({KIND_NOTE_OFF, 4'h0}, 7'd0, 7'd64));
    directed.push_back(make_msg({KIND_NOTE_ON, 4'h0}, 7'd5, 7'd100));
    // A true note-off cancels the waiting note.
    directed.push_back(make_msg({KIND_NOTE_OFF, 4'hA}, 7'd5, 7'd0));
    directed.push_back(make_msg({KIND_NOTE_OFF, 4'h0}, 7'd127, 7'd127));
    directed.push_back(make_msg({KIND_NOTE_ON, 4'h0}, 7'd127, 7'd0));
    directed.push_back(make_msg({KIND_NOTE_ON, 4'h0}, 7'd42, 7'd1));
    directed.push_back(make_msg({KIND_NOTE_ON, 4'h0}, 7'd43, 7'd5));
    directed.push_back(make_msg({KIND_NOTE_ON, 4'h0}, 7'd44, 7'd5));
    directed.push_back(make_msg({KIND_NOTE_OFF, 4'h0}, 7'd43, 7'd0));
    directed.push_back(make_msg({KIND_NOTE_ON, 4'h0}, 7'd42, 7'd0));
    directed.push_back(make_msg({KIND_CONTROL, 4'h0}, CTRL_CUTOFF, 7'd0));
    directed.push_back(make_msg({KIND_CONTROL, 4'h3}, CTRL_CUTOFF, 7'd127));
    directed.push_back(make_msg({KIND_CONTROL, 4'h0}, CTRL_FEEDBACK, 7'd127));
    directed.push_back(make_msg({KIND_CONTROL, 4'h0}, CTRL_DECAY, 7'd0));
    directed.push_back(make_msg({KIND_CONTROL, 4'h0}, CTRL_SUSTAIN, 7'd85));
    directed.push_back(make_msg({KIND_CONTROL, 4'hF}, CTRL_RELTIME, 7'd42));
    directed.push_back(make_msg({KIND_CONTROL, 4'h0}, 7'd0, 7'd127));
    directed.push_back(make_msg({KIND_CONTROL, 4'h0}, 7'd127, 7'd0));
    directed.push_back(make_msg({KIND_BEND, 4'h0}, 7'd0, 7'd0));
    directed.push_back(make_msg({KIND_BEND, 4'hF}, 7'd127, 7'd127));
    directed.push_back(make_msg(8'h00, 7'd127, 7'd127));
    directed.push_back(make_msg(8'hFF, 7'd0, 7'd0));
    directed.push_back(make_msg(8'hA5, 7'd1, 7'd1));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_msg(directed[i]);
    pause_sender(5);

    while (counted < MESSAGE_TARGET) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if ($urandom_range(0, 49) == 0)
          note_pool[$urandom_range(0, 5)] = 7'($urandom_range(0, 127));
        m = random_msg();
        send_msg(m);
        counted++;
      end
      if (!drained_once && counted >= MESSAGE_TARGET / 2) begin
        // Hold off until the handler has delivered everything it owes.
        req_valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0) @(posedge clk);
        drained_once = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 12));
      end
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
